// File: rtl/pressure_sensor_compensation_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the pressure compensation block
// ----------------------------------------------------------------------------
`ifndef PRESSURE_SENSOR_COMPENSATION_TOP_MACROS_SVH
`define PRESSURE_SENSOR_COMPENSATION_TOP_MACROS_SVH

// Check that cons holds in the same cycle as ante
`define PSC_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante
`define PSC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/pscomp_pkg.sv
// ----------------------------------------------------------------------------
// pscomp_pkg
// Shared types and constants for the pressure sensor compensation block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pscomp_pkg;

    // Field widths
    localparam int RAW_W     = 24;
    localparam int CAL_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int MUL_W     = 26;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int OUT_W     = 32;
    localparam int STATUS_W  = 2;
    localparam int REPORT_W  = 16;

    // Calibration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_C1 = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_C2 = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_C3 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_C4 = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_C5 = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_C6 = CFG_IDX_W'(5);

    // Status codes
    localparam logic [STATUS_W-1:0] STATUS_OK       = STATUS_W'(0);
    localparam logic [STATUS_W-1:0] STATUS_RAW_ZERO = STATUS_W'(1);
    localparam logic [STATUS_W-1:0] STATUS_RANGE    = STATUS_W'(2);

    typedef struct packed {
        logic [RAW_W-1:0] raw_pressure;
        logic [RAW_W-1:0] raw_temperature;
    } in_beat_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] pressure_tenth_mbar;
        logic signed [OUT_W-1:0] temperature_centi;
        logic [STATUS_W-1:0]     status;
        logic [REPORT_W-1:0]     reported_pressure_tenth_mbar;
        logic                    reported_valid;
    } out_beat_t;

    typedef struct packed {
        logic [CAL_W-1:0] pressure_sensitivity;
        logic [CAL_W-1:0] pressure_offset_coeff;
        logic [CAL_W-1:0] sens_temp_coeff;
        logic [CAL_W-1:0] offset_temp_coeff;
        logic [CAL_W-1:0] reference_temperature;
        logic [CAL_W-1:0] temp_coeff;
    } cal_t;

    // Result handed from the sequencer to the output stage
    typedef struct packed {
        logic                    done;
        logic signed [OUT_W-1:0] pressure;
        logic signed [OUT_W-1:0] temperature;
        logic [STATUS_W-1:0]     status;
    } core_res_t;

endpackage

`default_nettype wire

// File: rtl/pressure_sensor_compensation_top.sv
// Timing: each input beat runs the 13-step sequence through the shared 26x26
//   multiplier (a zero raw value skips to the final step), and a new beat is
//   accepted only once the result is loaded into the output register; the
//   hand-off waits while the output side stalls.
// Reset: synchronous, active low; clears calibration words, held pressure
//   and all handshake state.
// ----------------------------------------------------------------------------
// pressure_sensor_compensation_top
// Second-order pressure and temperature compensation of raw sensor words,
// with status and hold of the last good pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "pressure_sensor_compensation_top_macros.svh"

module pressure_sensor_compensation_top import pscomp_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire in_beat_t             s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output out_beat_t                 m_data,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CAL_W-1:0]     cfg_data
);

    cal_t                cal;
    core_res_t           core_res;
    logic                start;
    logic                out_free;
    logic                ok_beat;
    logic                ok_fresh;

    logic                busy_reg, busy_next;
    logic                m_valid_reg, m_valid_next;
    out_beat_t           m_data_reg, m_data_next;
    logic [REPORT_W-1:0] last_good_reg, last_good_next;
    logic                has_good_reg, has_good_next;

    pscomp_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cal       (cal)
    );

    pscomp_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start),
        .item    (s_data),
        .cal     (cal),
        .hold    (!out_free),
        .res     (core_res)
    );

    assign start    = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Track busy, load the output register and update the held pressure
    always_comb begin
        busy_next      = busy_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        last_good_next = last_good_reg;
        has_good_next  = has_good_reg;

        if (start) begin
            busy_next = 1'b1;
        end
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (core_res.done) begin
            busy_next                       = 1'b0;
            m_valid_next                    = 1'b1;
            m_data_next.pressure_tenth_mbar = core_res.pressure;
            m_data_next.temperature_centi   = core_res.temperature;
            m_data_next.status              = core_res.status;
            if (core_res.status == STATUS_OK) begin
                m_data_next.reported_pressure_tenth_mbar = core_res.pressure[REPORT_W-1:0];
                m_data_next.reported_valid               = 1'b1;
                last_good_next                           = core_res.pressure[REPORT_W-1:0];
                has_good_next                            = 1'b1;
            end else begin
                m_data_next.reported_pressure_tenth_mbar = has_good_reg ? last_good_reg : '0;
                m_data_next.reported_valid               = has_good_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
            last_good_reg <= '0;
            has_good_reg  <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            m_valid_reg   <= m_valid_next;
            last_good_reg <= last_good_next;
            has_good_reg  <= has_good_next;
        end
        m_data_reg <= m_data_next;
    end

    assign s_ready = !busy_reg;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // A good beat carries its own pressure as the reported one
    assign ok_beat  = m_valid_reg && (m_data_reg.status == STATUS_OK);
    assign ok_fresh = m_data_reg.reported_valid
                   && (m_data_reg.reported_pressure_tenth_mbar
                       == m_data_reg.pressure_tenth_mbar[REPORT_W-1:0]);

    // Checks on sequencing and result handling
    `PSC_ASSERT_SAME(a_done_while_busy, aclk, aresetn, core_res.done, busy_reg, "early result")
    `PSC_ASSERT_SAME(a_done_no_overwrite, aclk, aresetn, core_res.done, out_free, "beat lost")
    `PSC_ASSERT_NEXT(a_done_loads_output, aclk, aresetn, core_res.done, m_valid_reg, "no result")
    `PSC_ASSERT_SAME(a_ok_reports_fresh, aclk, aresetn, ok_beat, ok_fresh, "stale report")

endmodule

`default_nettype wire

// File: rtl/pscomp_mul.sv
// ----------------------------------------------------------------------------
// pscomp_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pscomp_mul import pscomp_pkg::*; (
    input  wire logic                     aclk,
    input  wire logic signed [MUL_W-1:0]  mul_a,
    input  wire logic signed [MUL_W-1:0]  mul_b,
    output logic signed [PROD_W-1:0]      prod
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    // Full-width signed product
    always_comb begin
        prod_next = mul_a * mul_b;
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// File: rtl/pscomp_cfg.sv
// ----------------------------------------------------------------------------
// pscomp_cfg
// Calibration register file, six 16-bit words written by index.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pscomp_cfg import pscomp_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CAL_W-1:0]     cfg_data,
    output cal_t                      cal
);

    cal_t cal_reg;
    cal_t cal_next;

    // Decode the write; drop indexes past the last word
    always_comb begin
        cal_next = cal_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_C1:  cal_next.pressure_sensitivity  = cfg_data;
                REG_C2:  cal_next.pressure_offset_coeff = cfg_data;
                REG_C3:  cal_next.sens_temp_coeff       = cfg_data;
                REG_C4:  cal_next.offset_temp_coeff     = cfg_data;
                REG_C5:  cal_next.reference_temperature = cfg_data;
                REG_C6:  cal_next.temp_coeff            = cfg_data;
                default: cal_next = cal_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_reg <= '0;
        end else begin
            cal_reg <= cal_next;
        end
    end

    assign cfg_ready = 1'b1;
    assign cal       = cal_reg;

endmodule

`default_nettype wire

// File: rtl/pscomp_core.sv
// ----------------------------------------------------------------------------
// pscomp_core
// Sequencer and datapath: runs the first- and second-order compensation
// through one shared multiplier, at most one product per state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pscomp_core import pscomp_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     start,
    input  wire in_beat_t item,
    input  wire cal_t     cal,
    input  wire logic     hold,
    output core_res_t     res
);

    localparam int DT_W   = RAW_W + 1;
    localparam int TEMP_W = 20;
    localparam int TI_W   = 18;
    localparam int SV_W   = 40;
    localparam int ACC_W  = 64;
    localparam int SQ_W   = 36;
    localparam int SPLIT  = 20;

    localparam logic signed [TEMP_W-1:0] TEMP_REF  = TEMP_W'(2000);
    localparam logic signed [TEMP_W-1:0] TEMP_DEEP = -TEMP_W'(1500);
    localparam logic signed [OUT_W-1:0]  P_MIN     = OUT_W'(5000);
    localparam logic signed [OUT_W-1:0]  P_MAX     = OUT_W'(40000);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DT,
        ST_M_TEMP,
        ST_M_SENS,
        ST_M_OFF,
        ST_M_DTSQ,
        ST_M_ESQ,
        ST_M_FSQ,
        ST_DEEP,
        ST_M_PLO,
        ST_M_PHI,
        ST_ACC,
        ST_SUB,
        ST_FINAL
    } state_t;

    // Signed divide by 2^k, rounding toward zero
    function automatic logic signed [ACC_W-1:0] trunc_div(
        input logic signed [ACC_W-1:0] x,
        input logic [5:0]              k
    );
        logic signed [ACC_W-1:0] bias;
        bias = x[ACC_W-1] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
        return (x + bias) >>> k;
    endfunction

    state_t                     state_reg, state_next;
    logic [RAW_W-1:0]           d1_reg, d1_next;
    logic [RAW_W-1:0]           d2_reg, d2_next;
    logic                       zero_reg, zero_next;
    logic signed [DT_W-1:0]     dt_reg, dt_next;
    logic signed [TEMP_W-1:0]   temp_reg, temp_next;
    logic [TI_W-1:0]            ti_reg, ti_next;
    logic                       low_reg, low_next;
    logic                       deep_reg, deep_next;
    logic signed [SV_W-1:0]     sens_reg, sens_next;
    logic signed [SV_W-1:0]     off_reg, off_next;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    core_res_t                  res_reg, res_next;

    logic signed [MUL_W-1:0]    mul_a, mul_b;
    logic signed [PROD_W-1:0]   prod;
    logic signed [ACC_W-1:0]    prod64;
    logic signed [ACC_W-1:0]    quot;
    logic signed [OUT_W-1:0]    p_val;
    logic signed [TEMP_W-1:0]   e_val, f_val;
    logic [2*DT_W-1:0]          tri_dt;
    logic [SQ_W-1:0]            sq;
    logic [SQ_W:0]              tri_sq;
    logic [SQ_W+1:0]            five_sq;
    logic [SQ_W+2:0]            seven_sq;
    logic [SV_W-1:0]            offi, sensi;

    // Shared multiplier
    pscomp_mul u_mul (
        .aclk  (aclk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .prod  (prod)
    );

    // Sequencer and datapath next state
    always_comb begin
        state_next = state_reg;
        d1_next    = d1_reg;
        d2_next    = d2_reg;
        zero_next  = zero_reg;
        dt_next    = dt_reg;
        temp_next  = temp_reg;
        ti_next    = ti_reg;
        low_next   = low_reg;
        deep_next  = deep_reg;
        sens_next  = sens_reg;
        off_next   = off_reg;
        acc_next   = acc_reg;
        res_next   = res_reg;
        res_next.done = 1'b0;
        mul_a      = '0;
        mul_b      = '0;

        prod64   = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
        e_val    = temp_reg - TEMP_REF;
        f_val    = temp_reg - TEMP_DEEP;
        tri_dt   = {prod[2*DT_W-2:0], 1'b0} + {1'b0, prod[2*DT_W-2:0]};
        sq       = prod[SQ_W-1:0];
        tri_sq   = {sq, 1'b0} + {1'b0, sq};
        five_sq  = {sq, 2'b0} + {2'b0, sq};
        seven_sq = {sq, 3'b0} - {3'b0, sq};
        quot     = trunc_div(acc_reg, 6'd13);
        p_val    = quot[OUT_W-1:0];
        offi     = '0;
        sensi    = '0;

        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    d1_next    = item.raw_pressure;
                    d2_next    = item.raw_temperature;
                    zero_next  = (item.raw_pressure == '0) || (item.raw_temperature == '0);
                    state_next = zero_next ? ST_FINAL : ST_DT;
                end
            end
            ST_DT: begin
                dt_next = $signed({1'b0, d2_reg})
                        - $signed({1'b0, cal.reference_temperature, 8'd0});
                state_next = ST_M_TEMP;
            end
            ST_M_TEMP: begin
                mul_a      = {{(MUL_W-DT_W){dt_reg[DT_W-1]}}, dt_reg};
                mul_b      = {{(MUL_W-CAL_W){1'b0}}, cal.temp_coeff};
                state_next = ST_M_SENS;
            end
            ST_M_SENS: begin
                // First-order temperature
                temp_next  = TEMP_W'(trunc_div(prod64, 6'd23)) + TEMP_REF;
                mul_a      = {{(MUL_W-DT_W){dt_reg[DT_W-1]}}, dt_reg};
                mul_b      = {{(MUL_W-CAL_W){1'b0}}, cal.sens_temp_coeff};
                state_next = ST_M_OFF;
            end
            ST_M_OFF: begin
                sens_next  = SV_W'(trunc_div(prod64, 6'd8))
                           + $signed({9'b0, cal.pressure_sensitivity, 15'b0});
                mul_a      = {{(MUL_W-DT_W){dt_reg[DT_W-1]}}, dt_reg};
                mul_b      = {{(MUL_W-CAL_W){1'b0}}, cal.offset_temp_coeff};
                state_next = ST_M_DTSQ;
            end
            ST_M_DTSQ: begin
                off_next   = SV_W'(trunc_div(prod64, 6'd7))
                           + $signed({8'b0, cal.pressure_offset_coeff, 16'b0});
                mul_a      = {{(MUL_W-DT_W){dt_reg[DT_W-1]}}, dt_reg};
                mul_b      = {{(MUL_W-DT_W){dt_reg[DT_W-1]}}, dt_reg};
                state_next = ST_M_ESQ;
            end
            ST_M_ESQ: begin
                // Second-order temperature term from dt squared
                low_next  = temp_reg < TEMP_REF;
                deep_next = temp_reg < TEMP_DEEP;
                if (low_next) begin
                    ti_next = {1'b0, tri_dt[DT_W*2-1:33]};
                end else begin
                    ti_next = {5'b0, prod[2*DT_W-2:36]};
                end
                mul_a      = {{(MUL_W-TEMP_W){e_val[TEMP_W-1]}}, e_val};
                mul_b      = {{(MUL_W-TEMP_W){e_val[TEMP_W-1]}}, e_val};
                state_next = ST_M_FSQ;
            end
            ST_M_FSQ: begin
                // Offset and sensitivity corrections from e squared
                if (low_reg) begin
                    offi  = {4'b0, tri_sq[SQ_W:1]};
                    sensi = {5'b0, five_sq[SQ_W+1:3]};
                end else begin
                    offi  = {8'b0, sq[SQ_W-1:4]};
                    sensi = '0;
                end
                off_next   = off_reg - $signed(offi);
                sens_next  = sens_reg - $signed(sensi);
                mul_a      = {{(MUL_W-TEMP_W){f_val[TEMP_W-1]}}, f_val};
                mul_b      = {{(MUL_W-TEMP_W){f_val[TEMP_W-1]}}, f_val};
                state_next = ST_DEEP;
            end
            ST_DEEP: begin
                // Extra corrections below -15 degC
                if (deep_reg) begin
                    offi      = {1'b0, seven_sq};
                    sensi     = {2'b0, sq, 2'b0};
                    off_next  = off_reg - $signed(offi);
                    sens_next = sens_reg - $signed(sensi);
                end
                temp_next  = temp_reg - $signed({2'b0, ti_reg});
                state_next = ST_M_PLO;
            end
            ST_M_PLO: begin
                mul_a      = {{(MUL_W-RAW_W){1'b0}}, d1_reg};
                mul_b      = {{(MUL_W-SPLIT){1'b0}}, sens_reg[SPLIT-1:0]};
                state_next = ST_M_PHI;
            end
            ST_M_PHI: begin
                acc_next   = prod64;
                mul_a      = {{(MUL_W-RAW_W){1'b0}}, d1_reg};
                mul_b      = {{(MUL_W-(SV_W-SPLIT)){sens_reg[SV_W-1]}},
                              sens_reg[SV_W-1:SPLIT]};
                state_next = ST_ACC;
            end
            ST_ACC: begin
                acc_next   = acc_reg + (prod64 <<< SPLIT);
                state_next = ST_SUB;
            end
            ST_SUB: begin
                acc_next   = trunc_div(acc_reg, 6'd21)
                           - {{(ACC_W-SV_W){off_reg[SV_W-1]}}, off_reg};
                state_next = ST_FINAL;
            end
            ST_FINAL: begin
                // Hand off once the output register can take the result
                if (!hold) begin
                    res_next.done = 1'b1;
                    if (zero_reg) begin
                        res_next.pressure    = '0;
                        res_next.temperature = '0;
                        res_next.status      = STATUS_RAW_ZERO;
                    end else begin
                        res_next.pressure    = p_val;
                        res_next.temperature = {{(OUT_W-TEMP_W){temp_reg[TEMP_W-1]}},
                                                temp_reg};
                        res_next.status      = ((p_val >= P_MIN) && (p_val <= P_MAX))
                                             ? STATUS_OK : STATUS_RANGE;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            res_reg.done <= 1'b0;
        end else begin
            state_reg <= state_next;
            res_reg   <= res_next;
        end
        d1_reg   <= d1_next;
        d2_reg   <= d2_next;
        zero_reg <= zero_next;
        dt_reg   <= dt_next;
        temp_reg <= temp_next;
        ti_reg   <= ti_next;
        low_reg  <= low_next;
        deep_reg <= deep_next;
        sens_reg <= sens_next;
        off_reg  <= off_next;
        acc_reg  <= acc_next;
    end

    assign res = res_reg;

endmodule

`default_nettype wire
